### sv/asp_pkg.sv
// package for the aging slot pool: fixed field widths, codes, defaults and
// the structs passed between the engine and the top level
// no dependencies
`default_nettype none

package asp_pkg;

  // widths fixed by the item and register formats
  localparam int EXPIRY_W    = 16;
  localparam int STEP_W      = 16;
  localparam int ANGLE_IN_W  = 16;
  localparam int SLOT_OUT_W  = 6;
  localparam int COUNT_OUT_W = 7;

  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd1229;  // 1.2 s in 1/1024 s

  // defaults for the top-level parameters
  localparam int DEF_ENTRIES    = 64;
  localparam int DEF_TIME_BITS  = 16;
  localparam int DEF_ANGLE_BITS = 16;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_EXPIRY = 1'b0;

  // item modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_ADD  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_CLAIM,
    ST_DONE
  } asp_state_t;

  typedef struct packed {
    logic                         mode;
    logic [STEP_W-1:0]            tick_time;
    logic signed [ANGLE_IN_W-1:0] direction_angle;
  } asp_req_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0]  slot_index;
    logic                   replaced_oldest;
    logic [COUNT_OUT_W-1:0] expired_count;
    logic [COUNT_OUT_W-1:0] live_count;
  } asp_res_t;

endpackage

`default_nettype wire

### sv/asp_slot_ram.sv
// slot memory: one write port, one read port with registered read data
// depends on nothing but its parameters
`default_nettype none

module asp_slot_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### sv/asp_cfg_regs.sv
// configuration registers behind the apb-style port: the expiry threshold
// depends on asp_pkg
`default_nettype none

module asp_cfg_regs
  import asp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [EXPIRY_W-1:0]   expiry
);

  logic [EXPIRY_W-1:0]     expiry_r;
  logic [EXPIRY_W-1:0]     expiry_nxt;
  logic [CFG_ADDR_W-3:0]   reg_idx;
  logic                    wr_hit;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite && pready && (reg_idx == REG_EXPIRY);

  always_comb begin
    expiry_nxt = expiry_r;
    if (wr_hit) begin
      expiry_nxt = pwdata[EXPIRY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RESET;
    end else begin
      expiry_r <= expiry_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EXPIRY: prdata = CFG_DATA_W'(expiry_r);
      default:    prdata = '0;
    endcase
  end

  assign expiry = expiry_r;

endmodule

`default_nettype wire

### sv/asp_engine.sv
// sweep engine: live bits, live count and the read-modify-write pass over
// the slot memory for ticks and adds; depends on asp_pkg and asp_slot_ram
`default_nettype none

module asp_engine
  import asp_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire asp_req_t            req,
  input  wire logic [EXPIRY_W-1:0] expiry,
  output logic                     busy,
  output logic                     res_valid,
  input  wire logic                res_take,
  output asp_res_t                 res
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = ANGLE_BITS + TIME_BITS;
  localparam int CMP_W  = (TIME_BITS > EXPIRY_W) ? TIME_BITS : EXPIRY_W;
  localparam int SUM_W  = ((CMP_W > STEP_W) ? CMP_W : STEP_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  asp_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   issue_r, issue_nxt;
  logic                   p_valid_r, p_valid_nxt;
  logic [IDX_W-1:0]       p_idx_r, p_idx_nxt;
  asp_req_t               req_r, req_nxt;
  logic [ENTRIES-1:0]     live_r, live_nxt;
  logic [CNT_W-1:0]       live_cnt_r, live_cnt_nxt;
  logic [CNT_W-1:0]       exp_cnt_r, exp_cnt_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;
  logic [TIME_BITS-1:0]   best_r, best_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0]       slot_r, slot_nxt;
  logic                   repl_r, repl_nxt;

  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [WORD_W-1:0]      rd_data;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [WORD_W-1:0]      wr_data;

  logic [TIME_BITS-1:0]   age_q;
  logic [ANGLE_BITS-1:0]  angle_q;
  logic [SUM_W-1:0]       age_sum;
  logic [TIME_BITS-1:0]   age_new;
  logic                   age_expired;
  logic [IDX_W-1:0]       claim_idx;

  asp_slot_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // memory word is {angle, age}
  assign age_q   = rd_data[TIME_BITS-1:0];
  assign angle_q = rd_data[WORD_W-1:TIME_BITS];

  // saturating age update and strict expiry compare
  assign age_sum     = SUM_W'(age_q) + SUM_W'(req_r.tick_time);
  assign age_new     = (age_sum > SUM_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                             : age_sum[TIME_BITS-1:0];
  assign age_expired = CMP_W'(age_new) > CMP_W'(expiry);

  assign claim_idx = found_r ? free_idx_r : best_idx_r;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    issue_nxt    = issue_r;
    p_valid_nxt  = p_valid_r;
    p_idx_nxt    = p_idx_r;
    req_nxt      = req_r;
    live_nxt     = live_r;
    live_cnt_nxt = live_cnt_r;
    exp_cnt_nxt  = exp_cnt_r;
    found_nxt    = found_r;
    free_idx_nxt = free_idx_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    slot_nxt     = slot_r;
    repl_nxt     = repl_r;
    rd_en        = 1'b0;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = p_idx_r;
    wr_data      = {angle_q, age_new};

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt      = req;
          idx_nxt      = '0;
          issue_nxt    = 1'b1;
          p_valid_nxt  = 1'b0;
          exp_cnt_nxt  = '0;
          found_nxt    = 1'b0;
          free_idx_nxt = '0;
          best_nxt     = '0;
          best_idx_nxt = '0;
          slot_nxt     = '0;
          repl_nxt     = 1'b0;
          state_nxt    = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // read stage
        p_valid_nxt = issue_r;
        p_idx_nxt   = idx_r;
        if (issue_r) begin
          rd_en = 1'b1;
          if (idx_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        // modify and write-back stage, one slot behind the read
        if (p_valid_r) begin
          if (req_r.mode == MODE_TICK) begin
            if (live_r[p_idx_r]) begin
              wr_en = 1'b1;
              if (age_expired) begin
                live_nxt[p_idx_r] = 1'b0;
                exp_cnt_nxt       = exp_cnt_r + 1'b1;
                live_cnt_nxt      = live_cnt_r - 1'b1;
              end
            end
          end else begin
            if (!live_r[p_idx_r] && !found_r) begin
              found_nxt    = 1'b1;
              free_idx_nxt = p_idx_r;
            end
            // strict compare keeps the lowest index on ties
            if (live_r[p_idx_r] && (age_q > best_r)) begin
              best_nxt     = age_q;
              best_idx_nxt = p_idx_r;
            end
          end
          if (p_idx_r == LAST_IDX) begin
            state_nxt = (req_r.mode == MODE_ADD) ? ST_CLAIM : ST_DONE;
          end
        end
      end
      ST_CLAIM: begin
        wr_en               = 1'b1;
        wr_addr             = claim_idx;
        wr_data             = {ANGLE_BITS'(req_r.direction_angle), {TIME_BITS{1'b0}}};
        live_nxt[claim_idx] = 1'b1;
        if (found_r) begin
          live_cnt_nxt = live_cnt_r + 1'b1;
        end
        slot_nxt  = claim_idx;
        repl_nxt  = !found_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      issue_r    <= 1'b0;
      p_valid_r  <= 1'b0;
      live_r     <= '0;
      live_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      issue_r    <= issue_nxt;
      p_valid_r  <= p_valid_nxt;
      live_r     <= live_nxt;
      live_cnt_r <= live_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    p_idx_r    <= p_idx_nxt;
    req_r      <= req_nxt;
    exp_cnt_r  <= exp_cnt_nxt;
    found_r    <= found_nxt;
    free_idx_r <= free_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    slot_r     <= slot_nxt;
    repl_r     <= repl_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  assign res.slot_index      = SLOT_OUT_W'(slot_r);
  assign res.replaced_oldest = repl_r;
  assign res.expired_count   = COUNT_OUT_W'(exp_cnt_r);
  assign res.live_count      = COUNT_OUT_W'(live_cnt_r);

`ifndef SYNTHESIS
  a_count_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
    live_cnt_r == CNT_W'($countones(live_r)))
    else $error("live count out of step with live bits");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write to the same slot in one cycle");

  a_replace_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLAIM && !found_r) |-> (live_cnt_r == CNT_W'(ENTRIES)))
    else $error("oldest slot replaced while a slot was free");

  a_claim_sets_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLAIM) |=> (live_r[slot_r] && live_cnt_r != '0))
    else $error("claimed slot not live after an add");
`endif

endmodule

`default_nettype wire

### sv/aging_slot_pool.sv
// aging slot pool
// A pool of ENTRIES timed slots. Each input transaction is a tick (mode 0),
// which ages every live slot by tick_time with saturation and frees those
// whose age passes expiry_time, or an add (mode 1), which claims the lowest
// free slot, or the oldest slot when all are live, and stores the angle.
// Every transaction gives exactly one result transaction.
// Channels use valid/stall; a transaction moves when valid is high and stall is low.
// expiry_time is for the user to write over the apb-style port while idle; not enforced.
// Each transaction takes one pass over the slot memory through its single
// read port, with a read stage and a modify and write-back stage, and an add
// then writes the claimed slot. in_stall is high from acceptance until the
// result has moved into the output register, so a new transaction is taken
// only once the previous result has moved on.
// The output register holds a result while out_stall is high; the engine
// may finish the next transaction meanwhile and then waits for it to clear.
// Reset (rst_n low, synchronous) frees every slot, empties the output
// register and sets expiry_time to 1229; slot ages and angles are left as
// they are and are rewritten on each claim.
// depends on asp_pkg, asp_cfg_regs, asp_engine, asp_slot_ram
`default_nettype none

module aging_slot_pool
  import asp_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [CFG_ADDR_W-1:0]        paddr,
  input  wire logic [CFG_DATA_W-1:0]        pwdata,
  output logic      [CFG_DATA_W-1:0]        prdata,
  output logic                              pready,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_mode,
  input  wire logic [STEP_W-1:0]            in_tick_time,
  input  wire logic signed [ANGLE_IN_W-1:0] in_direction_angle,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [SLOT_OUT_W-1:0]        out_slot_index,
  output logic                              out_replaced_oldest,
  output logic      [COUNT_OUT_W-1:0]       out_expired_count,
  output logic      [COUNT_OUT_W-1:0]       out_live_count
);

  logic [EXPIRY_W-1:0] expiry;
  asp_req_t            req;
  asp_res_t            eng_res;
  logic                eng_busy;
  logic                eng_res_valid;
  logic                res_take;
  logic                start;

  logic                out_valid_r, out_valid_nxt;
  asp_res_t            out_res_r, out_res_nxt;

  asp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .expiry  (expiry)
  );

  assign req.mode            = in_mode;
  assign req.tick_time       = in_tick_time;
  assign req.direction_angle = in_direction_angle;

  assign in_stall = eng_busy;
  assign start    = in_valid && !in_stall;

  // output register frees up when empty or when its transaction moves on
  assign res_take = !out_valid_r || !out_stall;

  asp_engine #(
    .ENTRIES    (ENTRIES),
    .TIME_BITS  (TIME_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .expiry    (expiry),
    .busy      (eng_busy),
    .res_valid (eng_res_valid),
    .res_take  (res_take),
    .res       (eng_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (eng_res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = eng_res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_slot_index      = out_res_r.slot_index;
  assign out_replaced_oldest = out_res_r.replaced_oldest;
  assign out_expired_count   = out_res_r.expired_count;
  assign out_live_count      = out_res_r.live_count;

endmodule

`default_nettype wire

### verif/aging_slot_pool_tb.sv
// testbench for aging_slot_pool: a directed table then random tick/add traffic,
// each result checked against its table row or a behavioural model of the pool
// depends on asp_pkg and the aging_slot_pool rtl
`default_nettype none

module aging_slot_pool_tb
  import asp_pkg::*;
();

  localparam int ENTRIES = DEF_ENTRIES;
  localparam int AGE_W = DEF_TIME_BITS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 80;
  localparam int IDLE_PCT = 38;
  localparam logic [CFG_ADDR_W-1:0] EXPIRY_ADDR = {REG_EXPIRY, 2'b00};

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  wire logic [CFG_DATA_W-1:0] prdata;
  wire logic pready;
  logic in_valid, in_mode;
  wire logic in_stall;
  logic [STEP_W-1:0] in_tick_time;
  logic signed [ANGLE_IN_W-1:0] in_direction_angle;
  wire logic out_valid;
  logic out_stall;
  wire logic [SLOT_OUT_W-1:0] out_slot_index;
  wire logic out_replaced_oldest;
  wire logic [COUNT_OUT_W-1:0] out_expired_count;
  wire logic [COUNT_OUT_W-1:0] out_live_count;

  aging_slot_pool dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_tick_time(in_tick_time), .in_direction_angle(in_direction_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_slot_index(out_slot_index), .out_replaced_oldest(out_replaced_oldest),
    .out_expired_count(out_expired_count), .out_live_count(out_live_count)
  );

  // model of the pool
  logic pool_live [ENTRIES];
  logic [AGE_W-1:0] pool_age [ENTRIES];
  logic [EXPIRY_W-1:0] pool_expiry;

  asp_res_t due_reports [$];
  int mismatches = 0;
  int unsigned cycles = 0;
  int hold_ask = 0;
  logic calm = 1'b0;

  typedef struct packed {
    logic is_cfg;
    logic mode;
    logic [STEP_W-1:0] step;  // register value on a cfg row
    logic [ANGLE_IN_W-1:0] angle;
    logic typed;
    asp_res_t res;
  } plan_row_t;

  localparam asp_res_t NO_RES = '0;

  // after reset, expiry 1229: equal age survives, one more tick expires,
  // then zero-step expiry at 0, saturation at 65535
  localparam plan_row_t PLAN [18] = '{
    '{1'b0, MODE_TICK, 16'd0,     16'h0000, 1'b1, '{6'd0, 1'b0, 7'd0, 7'd0}},
    '{1'b0, MODE_ADD,  16'd0,     16'h8000, 1'b1, '{6'd0, 1'b0, 7'd0, 7'd1}},
    '{1'b0, MODE_ADD,  16'd0,     16'h7FFF, 1'b1, '{6'd1, 1'b0, 7'd0, 7'd2}},
    '{1'b0, MODE_ADD,  16'hFFFF,  16'h0001, 1'b1, '{6'd2, 1'b0, 7'd0, 7'd3}},
    '{1'b0, MODE_TICK, 16'd1229,  16'hFFFF, 1'b1, '{6'd0, 1'b0, 7'd0, 7'd3}},
    '{1'b0, MODE_TICK, 16'd0,     16'h0000, 1'b1, '{6'd0, 1'b0, 7'd0, 7'd3}},
    '{1'b0, MODE_ADD,  16'd0,     16'h0000, 1'b1, '{6'd3, 1'b0, 7'd0, 7'd4}},
    '{1'b0, MODE_TICK, 16'd1,     16'h0000, 1'b1, '{6'd0, 1'b0, 7'd3, 7'd1}},
    '{1'b0, MODE_ADD,  16'd0,     16'hFFFF, 1'b1, '{6'd0, 1'b0, 7'd0, 7'd2}},
    '{1'b1, MODE_TICK, 16'd0,     16'h0000, 1'b0, NO_RES},
    '{1'b0, MODE_TICK, 16'd0,     16'h0000, 1'b1, '{6'd0, 1'b0, 7'd1, 7'd1}},
    '{1'b0, MODE_TICK, 16'hFFFF,  16'h0000, 1'b1, '{6'd0, 1'b0, 7'd1, 7'd0}},
    '{1'b1, MODE_TICK, 16'hFFFF,  16'h0000, 1'b0, NO_RES},
    '{1'b0, MODE_ADD,  16'd0,     16'h5555, 1'b1, '{6'd0, 1'b0, 7'd0, 7'd1}},
    '{1'b0, MODE_TICK, 16'hFFFF,  16'h0000, 1'b1, '{6'd0, 1'b0, 7'd0, 7'd1}},
    '{1'b0, MODE_TICK, 16'hFFFF,  16'h0000, 1'b1, '{6'd0, 1'b0, 7'd0, 7'd1}},
    '{1'b0, MODE_ADD,  16'd0,     16'hAAAA, 1'b0, NO_RES},
    '{1'b0, MODE_TICK, 16'd100,   16'h0000, 1'b0, NO_RES}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("aging_slot_pool_tb: done, errors");
    $finish;
  end

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic asp_res_t pool_step(input logic m, input logic [STEP_W-1:0] st);
    asp_res_t r;
    logic [AGE_W:0] sum;
    int pick;
    int n;
    r = '0;
    n = 0;
    if (m == MODE_TICK) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (pool_live[i]) begin
          sum = {1'b0, pool_age[i]} + st;
          pool_age[i] = sum[AGE_W] ? '1 : sum[AGE_W-1:0];
          if (pool_age[i] > pool_expiry) begin
            pool_live[i] = 1'b0;
            n++;
          end
        end
      end
      r.expired_count = COUNT_OUT_W'(n);
    end else begin
      pick = -1;
      for (int i = 0; i < ENTRIES && pick < 0; i++)
        if (!pool_live[i]) pick = i;
      // full pool: oldest goes, lowest index on ties
      if (pick < 0) begin
        pick = 0;
        for (int i = 1; i < ENTRIES; i++)
          if (pool_age[i] > pool_age[pick]) pick = i;
        r.replaced_oldest = 1'b1;
      end
      pool_live[pick] = 1'b1;
      pool_age[pick] = '0;
      r.slot_index = SLOT_OUT_W'(pick);
    end
    n = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (pool_live[i]) n++;
    r.live_count = COUNT_OUT_W'(n);
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] pick_step(input int span, input int big_pct);
    if ($urandom_range(0, 99) < big_pct) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return '1;
        default: return STEP_W'($urandom);
      endcase
    end
    return STEP_W'($urandom_range(0, span));
  endfunction

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string fld, input int want, input int got);
    if (want != got) note_error($sformatf("%s expected %0d, got %0d", fld, want, got));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_expiry(input logic [EXPIRY_W-1:0] v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= EXPIRY_ADDR;
    pwdata <= CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pool_expiry = v;
    @(posedge clk);
  endtask

  task automatic send_item(input logic m, input logic [STEP_W-1:0] st,
                           input logic [ANGLE_IN_W-1:0] ang, input logic typed,
                           input asp_res_t typed_res);
    asp_res_t got;
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_tick_time <= st;
    in_direction_angle <= ang;
    do @(posedge clk); while (in_stall);
    got = pool_step(m, st);
    due_reports.push_back(typed ? typed_res : got);
  endtask

  task automatic run_phase(input int items, input int add_pct, input int span,
                           input int big_pct);
    logic m;
    for (int i = 0; i < items; i++) begin
      m = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_TICK;
      send_item(m, pick_step(span, big_pct), ANGLE_IN_W'($urandom), 1'b0, NO_RES);
    end
  endtask

  // result side: checks every transaction and stalls at random or on request
  initial begin : result_side
    int hold_left;
    int hold_seen;
    asp_res_t want;
    hold_left = 0;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          note_error("result with nothing expected");
        end else begin
          want = due_reports.pop_front();
          check_field("slot_index", want.slot_index, out_slot_index);
          check_field("replaced_oldest", want.replaced_oldest, out_replaced_oldest);
          check_field("expired_count", want.expired_count, out_expired_count);
          check_field("live_count", want.live_count, out_live_count);
        end
      end
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_roll();
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_mode <= MODE_TICK;
    in_tick_time <= '0;
    in_direction_angle <= '0;
    for (int i = 0; i < ENTRIES; i++) begin
      pool_live[i] = 1'b0;
      pool_age[i] = '0;
    end
    pool_expiry = EXPIRY_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg) set_expiry(PLAN[i].step);
      else send_item(PLAN[i].mode, PLAN[i].step, PLAN[i].angle, PLAN[i].typed,
                     PLAN[i].res);
    end

    // no expiry: pool fills and adds overwrite the oldest slot
    run_phase(160, 80, 40, 3);
    // expiry at zero: any non-zero step frees everything
    set_expiry('0);
    run_phase(100, 50, 2, 5);
    // steady churn with no idling on either side
    set_expiry(EXPIRY_W'($urandom_range(300, 3000)));
    calm <= 1'b1;
    run_phase(150, 55, 300, 5);
    calm <= 1'b0;
    // receiver holds off long enough to back the pool up, then a full pause
    set_expiry(EXPIRY_RESET);
    hold_ask <= hold_ask + 1;
    run_phase(75, 60, 200, 5);
    drain();
    run_phase(75, 60, 200, 5);
    set_expiry(EXPIRY_W'($urandom_range(0, 65535)));
    run_phase(70, 60, 4000, 15);
    set_expiry(EXPIRY_W'($urandom_range(0, 65535)));
    run_phase(70, 60, 4000, 15);

    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("aging_slot_pool_tb: done, clean");
    end else begin
      $display("aging_slot_pool_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/asp_pkg.sv
sv/asp_slot_ram.sv
sv/asp_cfg_regs.sv
sv/asp_engine.sv
sv/aging_slot_pool.sv
verif/aging_slot_pool_tb.sv
